// ===== sv/xsc_pkg.sv =====
// ----------------------------------------------------------------------------
// xsc_pkg
// Shared widths, constants and types of the XOR subarray counter.
// ----------------------------------------------------------------------------
package xsc_pkg;

   localparam int VALUE_BITS_DEFAULT = 10;
   localparam int FIELD_BITS         = 10;
   localparam int COUNT_BITS         = 17;
   localparam int TOTAL_BITS         = 32;
   localparam int EPOCH_BITS         = 8;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CSR_ADDR_BITS      = 3;
   localparam int CSR_DATA_BITS      = 32;

   localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
   localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;
   localparam logic [EPOCH_BITS-1:0] EPOCH_WIPED = '0;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

   // register index as seen on paddr[2]
   localparam logic REG_TARGET_XOR = 1'b0;

   typedef struct packed {
      logic first;
      logic last;
      logic wipe;
   } xsc_flags_type;

   typedef struct packed {
      logic init_busy;
      logic clearing;
   } xsc_status_type;

endpackage

// ===== sv/xsc_front.sv =====
// ----------------------------------------------------------------------------
// xsc_front
// Accepts requests, tracks the prefix XOR and the table epoch, and queues
// table addresses and flags for the back end.
// ----------------------------------------------------------------------------
module xsc_front
   import xsc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FIELD_BITS-1:0] req_value,
   input  logic                  req_first,
   input  logic                  req_last,
   input  logic [FIELD_BITS-1:0] target_xor,
   input  logic                  q_full,
   input  xsc_status_type        status,
   output logic                  push,
   output logic [VALUE_BITS-1:0] push_p,
   output logic [VALUE_BITS-1:0] push_q,
   output logic [EPOCH_BITS-1:0] push_epoch,
   output xsc_flags_type         push_flags
);

   logic                  accept;
   logic                  wipe;
   logic [VALUE_BITS-1:0] base;
   logic [VALUE_BITS-1:0] prefix;
   logic [VALUE_BITS-1:0] prefix_ff, prefix_in;
   logic [EPOCH_BITS-1:0] epoch_item;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;

   assign req_ready = !q_full && !status.init_busy;

   always_comb begin
      accept = req_valid && req_ready;
      base   = req_first ? '0 : prefix_ff;
      prefix = base ^ VALUE_BITS'(req_value);
      wipe   = req_first && (epoch_ff == EPOCH_LAST);
      if (!req_first) begin
         epoch_item = epoch_ff;
      end else if (wipe) begin
         epoch_item = EPOCH_FIRST;
      end else begin
         epoch_item = epoch_ff + EPOCH_BITS'(1);
      end
      prefix_in = accept ? prefix : prefix_ff;
      epoch_in  = accept ? epoch_item : epoch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         epoch_ff  <= EPOCH_FIRST;
      end else begin
         prefix_ff <= prefix_in;
         epoch_ff  <= epoch_in;
      end
   end

   assign push             = accept;
   assign push_p           = prefix;
   assign push_q           = prefix ^ VALUE_BITS'(target_xor);
   assign push_epoch       = epoch_item;
   assign push_flags.first = req_first;
   assign push_flags.last  = req_last;
   assign push_flags.wipe  = wipe;

endmodule

// ===== sv/xsc_queue.sv =====
// ----------------------------------------------------------------------------
// xsc_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module xsc_queue
   import xsc_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slots_ff[rd_ptr_ff];

endmodule

// ===== sv/xsc_back.sv =====
// ----------------------------------------------------------------------------
// xsc_back
// Count table read-modify-write with forwarding, running total and the
// response register. Also runs the table clearing pass.
// ----------------------------------------------------------------------------
module xsc_back
   import xsc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  logic [VALUE_BITS-1:0] q_p,
   input  logic [VALUE_BITS-1:0] q_q,
   input  logic [EPOCH_BITS-1:0] q_epoch,
   input  xsc_flags_type         q_flags,
   output logic                  q_pop,
   output xsc_status_type        status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_BITS-1:0] rsp_ending_here,
   output logic [TOTAL_BITS-1:0] rsp_total_matches,
   output logic                  rsp_end_of_array
);

   localparam int DEPTH      = 1 << VALUE_BITS;
   localparam int ENTRY_BITS = EPOCH_BITS + COUNT_BITS;
   localparam int SUM_BITS   = TOTAL_BITS + 1;

   typedef enum logic [2:0] {
      ST_INIT = 3'b001,
      ST_RUN  = 3'b010,
      ST_WIPE = 3'b100
   } xsc_state_type;

   xsc_state_type state_ff, state_in;

   logic [ENTRY_BITS-1:0] mem [DEPTH];
   logic [ENTRY_BITS-1:0] rd_p_ff, rd_q_ff;

   logic [VALUE_BITS-1:0] clr_ff, clr_in;
   logic                  wiped_ff, wiped_in;

   logic                  s1_valid_ff, s1_valid_in;
   logic [VALUE_BITS-1:0] s1_p_ff, s1_q_ff;
   logic [EPOCH_BITS-1:0] s1_epoch_ff;
   logic                  s1_first_ff, s1_last_ff;

   logic                  fwd_valid_ff;
   logic [VALUE_BITS-1:0] fwd_addr_ff;
   logic [ENTRY_BITS-1:0] fwd_data_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] here_ff;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  eoa_ff;

   logic                  clearing, clr_done, need_wipe, issue, out_free, s1_move;
   logic                  wr_en;
   logic [VALUE_BITS-1:0] wr_addr;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [ENTRY_BITS-1:0] entry_p, entry_q;
   logic [COUNT_BITS-1:0] count_p, here, count_new;
   logic [TOTAL_BITS-1:0] total_base;
   logic [SUM_BITS-1:0]   sum;

   // control
   always_comb begin
      clearing  = (state_ff == ST_INIT) || (state_ff == ST_WIPE);
      clr_done  = clearing && (clr_ff == '1);
      out_free  = !rsp_valid_ff || rsp_ready;
      s1_move   = s1_valid_ff && out_free;
      need_wipe = q_valid && q_flags.wipe && !wiped_ff;
      issue     = (state_ff == ST_RUN) && q_valid && !need_wipe && (!s1_valid_ff || s1_move);

      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (clr_done) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (need_wipe && !s1_valid_ff) state_in = ST_WIPE;
         end
         ST_WIPE: begin
            if (clr_done) state_in = ST_RUN;
         end
         default: state_in = ST_INIT;
      endcase

      clr_in = clearing ? clr_ff + VALUE_BITS'(1) : '0;

      wiped_in = wiped_ff;
      if ((state_ff == ST_WIPE) && clr_done) begin
         wiped_in = 1'b1;
      end else if (issue && q_flags.wipe) begin
         wiped_in = 1'b0;
      end

      s1_valid_in  = issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // table lookup with forwarding of the latest write
   always_comb begin
      entry_p = (fwd_valid_ff && (fwd_addr_ff == s1_p_ff)) ? fwd_data_ff : rd_p_ff;
      entry_q = (fwd_valid_ff && (fwd_addr_ff == s1_q_ff)) ? fwd_data_ff : rd_q_ff;

      // stale epoch: entry reads as its array-start value
      if (entry_p[ENTRY_BITS-1 -: EPOCH_BITS] == s1_epoch_ff) begin
         count_p = entry_p[COUNT_BITS-1:0];
      end else begin
         count_p = (s1_p_ff == '0) ? COUNT_BITS'(1) : '0;
      end
      if (entry_q[ENTRY_BITS-1 -: EPOCH_BITS] == s1_epoch_ff) begin
         here = entry_q[COUNT_BITS-1:0];
      end else begin
         here = (s1_q_ff == '0) ? COUNT_BITS'(1) : '0;
      end

      count_new  = (count_p == COUNT_MAX) ? COUNT_MAX : count_p + COUNT_BITS'(1);
      total_base = s1_first_ff ? '0 : total_ff;
      sum        = {1'b0, total_base} + SUM_BITS'(here);
      total_in   = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

      wr_en = clearing || s1_move;
      if (clearing) begin
         wr_addr = clr_ff;
         wr_data = {EPOCH_WIPED, COUNT_BITS'(0)};
      end else begin
         wr_addr = s1_p_ff;
         wr_data = {s1_epoch_ff, count_new};
      end
   end

   // count table
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_p_ff <= mem[q_p];
         rd_q_ff <= mem[q_q];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         clr_ff       <= '0;
         wiped_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wiped_ff     <= wiped_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_ff || wr_en;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_p_ff     <= q_p;
         s1_q_ff     <= q_q;
         s1_epoch_ff <= q_epoch;
         s1_first_ff <= q_flags.first;
         s1_last_ff  <= q_flags.last;
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
      if (s1_move) begin
         here_ff <= here;
         eoa_ff  <= s1_last_ff;
      end
   end

   assign q_pop            = issue;
   assign status.init_busy = (state_ff == ST_INIT);
   assign status.clearing  = clearing;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ending_here   = here_ff;
   assign rsp_total_matches = total_ff;
   assign rsp_end_of_array  = eoa_ff;

endmodule

// ===== sv/xor_subarray_counter.sv =====
// ----------------------------------------------------------------------------
// xor_subarray_counter
// Counts contiguous runs of a streamed array whose XOR equals target_xor.
// ----------------------------------------------------------------------------
//
//   channel   ports                           direction   moves
//   req       req_valid/req_ready + fields    in          one element
//   rsp       rsp_valid/rsp_ready + fields    out         one result per element
//   csr       psel/penable/pwrite/paddr/...   in/out      target_xor at 0x0
//
// One request per cycle sustained while rsp is ready and no clearing pass runs;
// a response moves through the queue, the table read stage and the response
// register. The count table read-modify-write with write forwarding sets the rate.
// After reset the table is cleared with req_ready low.
// Every 255th array start re-clears the table before that element is processed,
// when the epoch tag wraps.
// A stalled rsp holds the pipeline; a 2-entry queue decouples req from it.
// ----------------------------------------------------------------------------
module xor_subarray_counter
   import xsc_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FIELD_BITS-1:0]    req_value,
   input  logic                     req_first,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COUNT_BITS-1:0]    rsp_ending_here,
   output logic [TOTAL_BITS-1:0]    rsp_total_matches,
   output logic                     rsp_end_of_array,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int QW = 2 * VALUE_BITS + EPOCH_BITS + $bits(xsc_flags_type);

   logic [FIELD_BITS-1:0] target_ff;
   logic                  csr_write;

   logic                  q_push, q_full, q_valid, q_pop;
   logic [VALUE_BITS-1:0] push_p, push_q, q_p, q_q;
   logic [EPOCH_BITS-1:0] push_epoch, q_epoch;
   xsc_flags_type         push_flags, q_flags;
   logic [QW-1:0]         push_data, pop_data;
   xsc_status_type        back_status;

   // csr
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_TARGET_XOR);
   assign prdata    = (paddr[2] == REG_TARGET_XOR) ? CSR_DATA_BITS'(target_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_write) begin
         target_ff <= pwdata[FIELD_BITS-1:0];
      end
   end

   xsc_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .req_first  (req_first),
      .req_last   (req_last),
      .target_xor (target_ff),
      .q_full     (q_full),
      .status     (back_status),
      .push       (q_push),
      .push_p     (push_p),
      .push_q     (push_q),
      .push_epoch (push_epoch),
      .push_flags (push_flags)
   );

   assign push_data = {push_p, push_q, push_epoch, push_flags};
   assign {q_p, q_q, q_epoch, q_flags} = pop_data;

   xsc_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   xsc_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_p               (q_p),
      .q_q               (q_q),
      .q_epoch           (q_epoch),
      .q_flags           (q_flags),
      .q_pop             (q_pop),
      .status            (back_status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ending_here   (rsp_ending_here),
      .rsp_total_matches (rsp_total_matches),
      .rsp_end_of_array  (rsp_end_of_array)
   );

   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !back_status.init_busy)
      else $error("request taken during table init");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !q_pop)
      else $error("queue pop during clearing pass");

   a_total_covers_here: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_total_matches >= TOTAL_BITS'(rsp_ending_here)))
      else $error("running total below per-element count");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for xor_subarray_counter. Streams arrays through the
// request channel, predicts every response from a local prefix-XOR count
// table, and compares them in order. Covers reset-state arrays, target_xor
// extremes, random arrays under random stalls, a long response hold-off and
// the table re-clear on epoch wrap.
// ----------------------------------------------------------------------------
module tb
   import xsc_pkg::*;
();

   localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
   localparam int TABLE_SIZE = 1 << VALUE_BITS;
   localparam logic [CSR_ADDR_BITS-1:0] TARGET_ADDR = CSR_ADDR_BITS'(0);
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR  = CSR_ADDR_BITS'(4);

   typedef struct packed {
      logic [COUNT_BITS-1:0] ending_here;
      logic [TOTAL_BITS-1:0] total_matches;
      logic                  end_of_array;
   } run_count_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FIELD_BITS-1:0]    req_value = '0;
   logic                     req_first = 1'b0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COUNT_BITS-1:0]    rsp_ending_here;
   logic [TOTAL_BITS-1:0]    rsp_total_matches;
   logic                     rsp_end_of_array;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   // prediction state
   logic [COUNT_BITS-1:0] seen_count [0:TABLE_SIZE-1];
   logic [VALUE_BITS-1:0] run_prefix;
   logic [TOTAL_BITS-1:0] run_total;
   logic [VALUE_BITS-1:0] target_xor;
   run_count_type         expected_counts [$];

   int failures = 0;
   bit gaps_on = 1'b1;
   int rsp_holdoff = 0;

   xor_subarray_counter i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .req_first         (req_first),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ending_here   (rsp_ending_here),
      .rsp_total_matches (rsp_total_matches),
      .rsp_end_of_array  (rsp_end_of_array),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("tb failed");
      $finish;
   end

   function automatic void restart_array();
      for (int i = 0; i < TABLE_SIZE; i++) seen_count[i] = '0;
      seen_count[0] = COUNT_BITS'(1);
      run_prefix = '0;
      run_total = '0;
   endfunction

   function automatic run_count_type count_xor_runs(logic [FIELD_BITS-1:0] value,
                                                    logic is_first, logic is_last);
      run_count_type         r;
      logic [VALUE_BITS-1:0] key;
      logic [TOTAL_BITS:0]   sum;
      if (is_first) restart_array();
      run_prefix = run_prefix ^ value[VALUE_BITS-1:0];
      key = run_prefix ^ target_xor;
      r.ending_here = seen_count[key];
      sum = {1'b0, run_total} + r.ending_here;
      run_total = sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      if (seen_count[run_prefix] != COUNT_MAX)
         seen_count[run_prefix] = seen_count[run_prefix] + 1'b1;
      r.total_matches = run_total;
      r.end_of_array = is_last;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // biased toward values that close a matching run
   function automatic logic [FIELD_BITS-1:0] pick_value();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return FIELD_BITS'(target_xor);
         2: return FIELD_BITS'($urandom_range(0, 3));
         3: return FIELD_BITS'(target_xor ^ VALUE_BITS'($urandom_range(0, 3)));
         default: return FIELD_BITS'($urandom_range(0, (1 << FIELD_BITS) - 1));
      endcase
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   task automatic send_element(input logic [FIELD_BITS-1:0] value,
                               input logic is_first, input logic is_last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_first <= is_first;
      req_last <= is_last;
      do @(posedge clock); while (!req_ready);
      expected_counts.push_back(count_xor_runs(value, is_first, is_last));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_counts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr[2] == REG_TARGET_XOR) target_xor = data[VALUE_BITS-1:0];
      @(posedge clock);
   endtask

   task automatic csr_check_target();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= TARGET_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      compare_field("prdata", CSR_DATA_BITS'(target_xor), prdata);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_arrays(input int count);
      int sent;
      int kind;
      int len;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         len = (kind < 7) ? $urandom_range(1, 12) : $urandom_range(13, 40);
         // kind 8: array never closed, kind 9: continues without a start
         for (int i = 0; i < len; i++) begin
            send_element(pick_value(), (i == 0) && (kind != 9), (i == len - 1) && (kind != 8));
            sent++;
         end
      end
   endtask

   // response side: random stalls, long hold-off on request, result check
   initial begin
      int stall_left;
      run_count_type want;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               failures++;
               $error("result with no request pending");
            end else begin
               want = expected_counts.pop_front();
               compare_field("ending_here", 32'(want.ending_here), 32'(rsp_ending_here));
               compare_field("total_matches", want.total_matches, rsp_total_matches);
               compare_field("end_of_array", 32'(want.end_of_array), 32'(rsp_end_of_array));
            end
         end
         if (rsp_holdoff > 0) begin
            stall_left = rsp_holdoff;
            rsp_holdoff = 0;
         end
         if (stall_left == 0) stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // elements before any start of array see the reset state
   task automatic test_reset_state();
      send_element(FIELD_BITS'(5), 1'b0, 1'b0);
      send_element(FIELD_BITS'(5), 1'b0, 1'b1);
      send_element('1, 1'b0, 1'b0);
      send_element('1, 1'b0, 1'b1);
      drain_results();
   endtask

   task automatic test_field_extremes();
      csr_write(TARGET_ADDR, '1);
      csr_check_target();
      csr_write(SPARE_ADDR, CSR_DATA_BITS'(32'h155));
      csr_check_target();
      send_element('1, 1'b1, 1'b1);
      send_element('0, 1'b1, 1'b0);
      send_element('1, 1'b0, 1'b0);
      send_element('1, 1'b0, 1'b0);
      send_element(FIELD_BITS'(10'h155), 1'b0, 1'b0);
      send_element(FIELD_BITS'(10'h2AA), 1'b0, 1'b0);
      send_element('0, 1'b0, 1'b1);
      send_element('1, 1'b0, 1'b0);
      send_element(FIELD_BITS'(10'h2AA), 1'b1, 1'b0);
      send_element(FIELD_BITS'(10'h155), 1'b0, 1'b1);
      drain_results();
   endtask

   task automatic test_target_sweep();
      csr_write(TARGET_ADDR, '0);
      gaps_on = 1'b0;
      send_random_arrays(15);
      gaps_on = 1'b1;
      send_random_arrays(15);
      drain_results();
      csr_write(TARGET_ADDR, CSR_DATA_BITS'(TABLE_SIZE - 1));
      csr_check_target();
      send_random_arrays(20);
      drain_results();
      csr_write(TARGET_ADDR, CSR_DATA_BITS'($urandom_range(0, TABLE_SIZE - 1)));
      send_random_arrays(20);
      drain_results();
      // junk above the register width must be dropped
      csr_write(TARGET_ADDR, {$urandom} | ~CSR_DATA_BITS'(TABLE_SIZE - 1));
      csr_check_target();
      send_random_arrays(20);
      drain_results();
   endtask

   task automatic test_rsp_holdoff();
      csr_write(TARGET_ADDR, CSR_DATA_BITS'($urandom_range(0, 3)));
      rsp_holdoff = 120;
      gaps_on = 1'b0;
      send_random_arrays(20);
      gaps_on = 1'b1;
      drain_results();
   endtask

   // enough array starts to wrap the epoch tag at least once
   task automatic test_epoch_wrap();
      csr_write(TARGET_ADDR, CSR_DATA_BITS'($urandom_range(0, 3)));
      for (int a = 0; a < 260; a++) begin
         if (a % 10 != 0) begin
            send_element(pick_value(), 1'b1, 1'b1);
         end else begin
            send_element(pick_value(), 1'b1, 1'b0);
            send_element(pick_value(), 1'b0, 1'b1);
         end
      end
      drain_results();
   endtask

   initial begin
      restart_array();
      target_xor = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_reset_state();
      test_field_extremes();
      test_target_sweep();
      test_rsp_holdoff();
      test_epoch_wrap();
      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
